### rtl/htfa_pkg.sv
// Shared types and constants for the hole table fit allocator.
// Depends on nothing; every other file imports it.
package htfa_pkg;

  // Fixed field widths of the transaction and configuration ports
  localparam int SIZE_W     = 16;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Operation codes on in_func
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Placement rule held in fit_mode
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // Register index (word address) of fit_mode
  localparam logic REG_FIT_MODE = 1'b0;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Controls broadcast to every cell of the hole chain
  typedef struct packed {
    logic              fit_best;
    logic [SIZE_W-1:0] amount;
  } cell_ctl_t;

endpackage

### rtl/htfa_cell.sv
// One slot of the hole table: holds a hole and refines the running candidate.
// Depends on htfa_pkg.
module htfa_cell #(
  parameter int ADDR_W = 16,
  parameter int IDX_W  = 4,
  parameter int CNT_W  = 5,
  parameter int IDX    = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  htfa_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]            hole_cnt,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic [ADDR_W-1:0]           wr_base,
  input  logic [htfa_pkg::SIZE_W-1:0] wr_size,
  input  logic                        cand_in_found,
  input  logic [ADDR_W-1:0]           cand_in_base,
  input  logic [htfa_pkg::SIZE_W-1:0] cand_in_size,
  input  logic [IDX_W-1:0]            cand_in_idx,
  output logic                        cand_out_found,
  output logic [ADDR_W-1:0]           cand_out_base,
  output logic [htfa_pkg::SIZE_W-1:0] cand_out_size,
  output logic [IDX_W-1:0]            cand_out_idx
);
  import htfa_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] size_r;
  logic              found_r;
  logic [ADDR_W-1:0] cbase_r;
  logic [SIZE_W-1:0] csize_r;
  logic [IDX_W-1:0]  cidx_r;
  logic              slot_live;
  logic              fits;
  logic              better;

  // Hole storage, written on an add or on an allocate writeback
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(IDX))) begin
      base_r <= wr_base;
      size_r <= wr_size;
    end
  end

  // Compare this slot against the candidate from the left neighbor
  assign slot_live = (CNT_W'(IDX) < hole_cnt);
  assign fits      = slot_live && (size_r >= ctl.amount);

  always_comb begin
    if (!fits) begin
      better = 1'b0;
    end else if (!cand_in_found) begin
      better = 1'b1;
    end else if (ctl.fit_best == FIT_FIRST) begin
      better = (base_r < cand_in_base);
    end else begin
      better = (size_r < cand_in_size) ||
               ((size_r == cand_in_size) && (base_r < cand_in_base));
    end
  end

  // Hand the winner to the right neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= cand_in_found || better;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      cbase_r <= base_r;
      csize_r <= size_r;
      cidx_r  <= IDX_W'(IDX);
    end else begin
      cbase_r <= cand_in_base;
      csize_r <= cand_in_size;
      cidx_r  <= cand_in_idx;
    end
  end

  assign cand_out_found = found_r;
  assign cand_out_base  = cbase_r;
  assign cand_out_size  = csize_r;
  assign cand_out_idx   = cidx_r;

endmodule

### rtl/hole_table_fit_allocator.sv
// Top level of the hole table fit allocator: sequencer, config port, cell chain.
// Depends on htfa_pkg and htfa_cell.
//
// A table of up to MAX_HOLES free holes, one per cell in a chain. An add
// transaction (in_func = 0) leaves busy low, and its result strobes on
// out_valid in the next cycle. An allocate transaction (in_func = 1) keeps
// busy high while the best candidate walks the cell chain one cell per clock,
// and the final busy cycle writes the chosen hole back. Its result strobes on
// out_valid in the first cycle with busy low; a new transaction may be started
// in that same cycle. Each result is shown for exactly one cycle and cannot be
// held off, so the receiver must take it when out_valid is high. fit_mode
// (APB word 0) selects first fit (lowest base) or best fit (smallest size,
// lower base on ties); write it only while the block is idle.
module hole_table_fit_allocator #(
  parameter int MAX_HOLES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [ADDR_BITS-1:0]            in_hole_start,
  input  logic [htfa_pkg::SIZE_W-1:0]     in_amount,
  // result channel
  output logic                            out_valid,
  output logic [htfa_pkg::STAT_W-1:0]     out_status,
  output logic [ADDR_BITS-1:0]            out_granted_address,
  output logic [htfa_pkg::SLOT_W-1:0]     out_slot_used,
  output logic [htfa_pkg::SIZE_W-1:0]     out_left_in_hole,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [htfa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [htfa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [htfa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import htfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int CNT_W = $clog2(MAX_HOLES + 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     step_r;
  logic [CNT_W-1:0]     count_r;
  logic [SIZE_W-1:0]    amount_r;
  logic                 fit_mode_r;
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [SIZE_W-1:0]    out_left_r;

  logic                 accept;
  logic                 do_add;
  logic                 table_full;
  logic                 scan_done;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [ADDR_BITS-1:0] wr_base;
  logic [SIZE_W-1:0]    wr_size;
  logic                 cfg_wr;
  cell_ctl_t            ctl;

  // Candidate links along the chain; entry 0 feeds the first cell
  logic                 link_found [MAX_HOLES+1];
  logic [ADDR_BITS-1:0] link_base  [MAX_HOLES+1];
  logic [SIZE_W-1:0]    link_size  [MAX_HOLES+1];
  logic [IDX_W-1:0]     link_idx   [MAX_HOLES+1];

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIT_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
    end else if (cfg_wr) begin
      fit_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_FIT_MODE) ? CFG_DATA_W'(fit_mode_r) : '0;

  // Transaction decode
  assign accept     = start && !busy_r;
  assign do_add     = accept && (in_func == FUNC_ADD);
  assign table_full = (count_r == CNT_W'(MAX_HOLES));
  assign scan_done  = busy_r && (step_r == CNT_W'(MAX_HOLES));

  // Table write: new hole on add, shrunk hole at the end of a scan
  always_comb begin
    if (do_add) begin
      wr_en   = !table_full;
      wr_idx  = count_r[IDX_W-1:0];
      wr_base = in_hole_start;
      wr_size = in_amount;
    end else begin
      wr_en   = scan_done && link_found[MAX_HOLES];
      wr_idx  = link_idx[MAX_HOLES];
      wr_base = link_base[MAX_HOLES] + ADDR_BITS'(amount_r);
      wr_size = link_size[MAX_HOLES] - amount_r;
    end
  end

  // Sequencer: step counter over the chain length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= '0;
      count_r <= '0;
    end else begin
      if (accept && (in_func == FUNC_ALLOC)) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (scan_done) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
      end
      if (do_add && !table_full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_func == FUNC_ALLOC)) begin
      amount_r <= in_amount;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= do_add || scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      out_status_r <= table_full ? ST_FULL : ST_ADDED;
      out_addr_r   <= '0;
      out_slot_r   <= table_full ? '0 : SLOT_W'(count_r);
      out_left_r   <= table_full ? '0 : in_amount;
    end else if (scan_done) begin
      if (link_found[MAX_HOLES]) begin
        out_status_r <= ST_GRANTED;
        out_addr_r   <= link_base[MAX_HOLES];
        out_slot_r   <= SLOT_W'(link_idx[MAX_HOLES]);
        out_left_r   <= wr_size;
      end else begin
        out_status_r <= ST_NO_FIT;
        out_addr_r   <= '0;
        out_slot_r   <= '0;
        out_left_r   <= '0;
      end
    end
  end

  assign busy                = busy_r;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_slot_used       = out_slot_r;
  assign out_left_in_hole    = out_left_r;

  // Cell chain
  assign ctl.fit_best = fit_mode_r;
  assign ctl.amount   = amount_r;

  assign link_found[0] = 1'b0;
  assign link_base[0]  = '0;
  assign link_size[0]  = '0;
  assign link_idx[0]   = '0;

  for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
    htfa_cell #(
      .ADDR_W (ADDR_BITS),
      .IDX_W  (IDX_W),
      .CNT_W  (CNT_W),
      .IDX    (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .hole_cnt       (count_r),
      .wr_en          (wr_en),
      .wr_idx         (wr_idx),
      .wr_base        (wr_base),
      .wr_size        (wr_size),
      .cand_in_found  (link_found[g]),
      .cand_in_base   (link_base[g]),
      .cand_in_size   (link_size[g]),
      .cand_in_idx    (link_idx[g]),
      .cand_out_found (link_found[g+1]),
      .cand_out_base  (link_base[g+1]),
      .cand_out_size  (link_size[g+1]),
      .cand_out_idx   (link_idx[g+1])
    );
  end

`ifndef SYNTHESIS
  // Step counter never runs past the chain length
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= CNT_W'(MAX_HOLES)))
    else $error("scan step past chain length");

  // Hole count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_HOLES))
    else $error("hole count overflow");

  // A scan result strobes in the first cycle with busy low
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> (out_valid && !busy_r))
    else $error("scan finished without a result");

  // A grant is impossible with an empty table
  a_grant_needs_hole: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_done && (count_r == '0)) |-> !link_found[MAX_HOLES])
    else $error("grant from empty table");
`endif

endmodule
